// ===== design/bahd_pkg.sv =====
// ----------------------------------------------------------------------------
// bahd_pkg: shared types and constants for the block-average hold decimator
// Field widths, register indexes, sequencer states and the digit adder used
// by the serial datapath.
// ----------------------------------------------------------------------------
package bahd_pkg;

    // fixed width of every sample field on the channels
    localparam int FIELD_W = 32;

    // configuration port
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LOSS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO_IN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWNMIX   = 2'd2;

    localparam logic [CFG_DATA_W-1:0] LOSS_RESET = 5'd1;

    // width of one digit of the serial adder
    localparam int DIGIT_W = 4;

    typedef logic [DIGIT_W-1:0] digit_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,      // waiting for a frame
        ST_PRE_ADD,   // downmix: l + r, one digit a cycle
        ST_PRE_RND,   // downmix: add sign so the halving truncates toward zero
        ST_HALVE,     // downmix: arithmetic shift right by one
        ST_ACC,       // add the frame into the running sums
        ST_NEG_IN,    // take magnitudes of the sums
        ST_DIV,       // restoring division by the frame count, one bit a cycle
        ST_NEG_OUT,   // restore the sign of the quotients
        ST_EMIT       // repeat the average once per frame of the block
    } state_t;

    // one digit of an add: carry out on top
    function automatic logic [DIGIT_W:0] digit_add(input digit_t x, input digit_t y,
                                                   input logic cin);
        return {1'b0, x} + {1'b0, y} + {{DIGIT_W{1'b0}}, cin};
    endfunction

endpackage

// ===== design/bahd_frame_if.sv =====
// ----------------------------------------------------------------------------
// bahd_frame_if: input frame channel
// One mono sample or a left/right pair, plus the end-of-stream mark.
// ----------------------------------------------------------------------------
interface bahd_frame_if import bahd_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] sample_left;
    logic signed [FIELD_W-1:0] sample_right;
    logic                      end_of_stream;

    modport source (output valid, output sample_left, output sample_right,
                    output end_of_stream, input ready);
    modport sink   (input valid, input sample_left, input sample_right,
                    input end_of_stream, output ready);

endinterface

// ===== design/bahd_result_if.sv =====
// ----------------------------------------------------------------------------
// bahd_result_if: output result channel
// One held block average per word, with the last-of-block mark.
// ----------------------------------------------------------------------------
interface bahd_result_if import bahd_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] left_out;
    logic signed [FIELD_W-1:0] right_out;
    logic                      run_last;

    modport source (output valid, output left_out, output right_out,
                    output run_last, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input run_last, output ready);

endinterface

// ===== design/block_average_hold_decimator_core.sv =====
// ----------------------------------------------------------------------------
// block_average_hold_decimator_core: audio bit-crusher core
// Sums frames over blocks of 'loss', divides by the frame count and repeats
// the average once per frame of the block. Digit-serial datapath.
//
//  channel  | dir | handshake          | word
//  ---------+-----+--------------------+------------------------------------
//  frame    | in  | valid/ready        | sample_left, sample_right, eos
//  result   | out | valid/ready        | left_out, right_out, run_last
//  cfg      | in  | cfg_we (no ready)  | cfg_index, cfg_data
//
// Sizes: ND = ceil((SAMPLE_BITS+clog2(MAX_LOSS+1))/4) digits and AW = 4*ND
// (ND = 10, AW = 40 at the defaults). A frame is added into the sums through
// the 4-bit serial adder, after a pre-add, rounding pass and halving in downmix.
// A closing frame then runs the sign pass, the one-bit-a-cycle divider and the
// sign restore, and n result words follow, one per cycle when not stalled.
// Reset clears the sums, the frame count and the registers (loss 1, stereo).
// frame.ready is high only while idle; a stalled result holds everything.
// ----------------------------------------------------------------------------
module block_average_hold_decimator_core
    import bahd_pkg::*;
#(
    parameter int MAX_LOSS    = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bahd_frame_if.sink            frame,
    bahd_result_if.source         result
);

    // derived sizes
    localparam int CW    = $clog2(MAX_LOSS + 1);            // frame counts
    localparam int SUM_W = SAMPLE_BITS + CW;                 // running sums
    localparam int ND    = (SUM_W + DIGIT_W - 1) / DIGIT_W;  // digits a pass
    localparam int AW    = ND * DIGIT_W;                     // serial word
    localparam int DCW   = $clog2(ND);
    localparam int BCW   = $clog2(AW);

    // control registers
    state_t                  state_reg, state_next;
    logic [CFG_DATA_W-1:0]   loss_reg, loss_next;
    logic                    stereo_reg, stereo_next;
    logic                    downmix_reg, downmix_next;
    logic [CW-1:0]           held_reg, held_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           kcnt_reg, kcnt_next;
    logic [DCW-1:0]          dcnt_reg, dcnt_next;
    logic [BCW-1:0]          bcnt_reg, bcnt_next;
    logic [AW-1:0]           lsum_reg, lsum_next;
    logic [AW-1:0]           rsum_reg, rsum_next;

    // payload registers
    logic [AW-1:0]           a_reg, a_next;
    logic [AW-1:0]           b_reg, b_next;
    logic                    ca_reg, ca_next;
    logic                    cb_reg, cb_next;
    logic                    lneg_reg, lneg_next;
    logic                    rneg_reg, rneg_next;
    logic                    eos_reg, eos_next;
    logic [CW:0]             reml_reg, reml_next;
    logic [CW:0]             remr_reg, remr_next;

    // shared decode
    logic                    frame_acc;
    logic                    result_acc;
    logic                    first_dig;
    logic                    last_dig;
    logic                    last_bit;
    logic                    mono_out;
    logic [CW-1:0]           eff_loss;
    logic [CW-1:0]           held_inc;
    logic                    close_blk;
    logic                    lneg_cur;
    logic                    rneg_cur;
    logic [DIGIT_W:0]        dl;
    logic [DIGIT_W:0]        dr;
    logic [CW:0]             shl;
    logic [CW:0]             shr;
    logic                    qbl;
    logic                    qbr;

    assign frame_acc  = frame.valid && frame.ready;
    assign result_acc = result.valid && result.ready;
    assign first_dig  = (dcnt_reg == '0);
    assign last_dig   = (dcnt_reg == DCW'(ND - 1));
    assign last_bit   = (bcnt_reg == BCW'(AW - 1));
    assign mono_out   = !stereo_reg || downmix_reg;
    assign held_inc   = held_reg + 1'b1;
    assign close_blk  = (held_inc >= eff_loss) || eos_reg;

    // loss saturated into 1..MAX_LOSS
    always_comb
    begin
        if (loss_reg == '0)
            eff_loss = CW'(1);
        else if (int'(loss_reg) > MAX_LOSS)
            eff_loss = CW'(MAX_LOSS);
        else
            eff_loss = CW'(loss_reg);
    end

    // sign of the sums, sampled on the first digit of the input sign pass
    assign lneg_cur = first_dig ? lsum_reg[AW-1] : lneg_reg;
    assign rneg_cur = first_dig ? rsum_reg[AW-1] : rneg_reg;

    // restoring divider step: bring in the next dividend bit
    assign shl = {reml_reg[CW-1:0], lsum_reg[AW-1]};
    assign shr = {remr_reg[CW-1:0], rsum_reg[AW-1]};
    assign qbl = (shl >= {1'b0, n_reg});
    assign qbr = (shr >= {1'b0, n_reg});

    // configuration writes
    always_comb
    begin
        loss_next    = loss_reg;
        stereo_next  = stereo_reg;
        downmix_next = downmix_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOSS:      loss_next    = cfg_data;
                REG_STEREO_IN: stereo_next  = cfg_data[0];
                REG_DOWNMIX:   downmix_next = cfg_data[0];
                default:       ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (frame_acc)
                    state_next = (stereo_reg && downmix_reg) ? ST_PRE_ADD : ST_ACC;
            ST_PRE_ADD:
                if (last_dig)
                    state_next = ST_PRE_RND;
            ST_PRE_RND:
                if (last_dig)
                    state_next = ST_HALVE;
            ST_HALVE:
                state_next = ST_ACC;
            ST_ACC:
                if (last_dig)
                    state_next = close_blk ? ST_NEG_IN : ST_IDLE;
            ST_NEG_IN:
                if (last_dig)
                    state_next = ST_DIV;
            ST_DIV:
                if (last_bit)
                    state_next = ST_NEG_OUT;
            ST_NEG_OUT:
                if (last_dig)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (result_acc && result.run_last)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        ca_next   = ca_reg;
        cb_next   = cb_reg;
        lneg_next = lneg_reg;
        rneg_next = rneg_reg;
        eos_next  = eos_reg;
        reml_next = reml_reg;
        remr_next = remr_reg;
        lsum_next = lsum_reg;
        rsum_next = rsum_reg;
        held_next = held_reg;
        n_next    = n_reg;
        kcnt_next = kcnt_reg;
        dcnt_next = dcnt_reg;
        bcnt_next = bcnt_reg;
        dl        = '0;
        dr        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                dcnt_next = '0;
                if (frame_acc)
                begin
                    // right sample kept for stereo and for the downmix pre-add
                    a_next   = AW'($signed(frame.sample_left[SAMPLE_BITS-1:0]));
                    b_next   = stereo_reg
                               ? AW'($signed(frame.sample_right[SAMPLE_BITS-1:0]))
                               : '0;
                    eos_next = frame.end_of_stream;
                end
            end

            // t = l + r
            ST_PRE_ADD:
            begin
                dl        = digit_add(a_reg[DIGIT_W-1:0], b_reg[DIGIT_W-1:0],
                                      first_dig ? 1'b0 : ca_reg);
                a_next    = {dl[DIGIT_W-1:0], a_reg[AW-1:DIGIT_W]};
                b_next    = {b_reg[DIGIT_W-1:0], b_reg[AW-1:DIGIT_W]};
                ca_next   = dl[DIGIT_W];
                dcnt_next = last_dig ? '0 : dcnt_reg + 1'b1;
            end

            // t + sign(t), so the shift rounds toward zero
            ST_PRE_RND:
            begin
                dl        = digit_add(a_reg[DIGIT_W-1:0], '0,
                                      first_dig ? a_reg[AW-1] : ca_reg);
                a_next    = {dl[DIGIT_W-1:0], a_reg[AW-1:DIGIT_W]};
                ca_next   = dl[DIGIT_W];
                dcnt_next = last_dig ? '0 : dcnt_reg + 1'b1;
            end

            ST_HALVE:
            begin
                a_next    = AW'($signed(a_reg) >>> 1);
                b_next    = '0;
                dcnt_next = '0;
            end

            // sums += frame
            ST_ACC:
            begin
                dl        = digit_add(lsum_reg[DIGIT_W-1:0], a_reg[DIGIT_W-1:0],
                                      first_dig ? 1'b0 : ca_reg);
                dr        = digit_add(rsum_reg[DIGIT_W-1:0], b_reg[DIGIT_W-1:0],
                                      first_dig ? 1'b0 : cb_reg);
                lsum_next = {dl[DIGIT_W-1:0], lsum_reg[AW-1:DIGIT_W]};
                rsum_next = {dr[DIGIT_W-1:0], rsum_reg[AW-1:DIGIT_W]};
                a_next    = {a_reg[DIGIT_W-1:0], a_reg[AW-1:DIGIT_W]};
                b_next    = {b_reg[DIGIT_W-1:0], b_reg[AW-1:DIGIT_W]};
                ca_next   = dl[DIGIT_W];
                cb_next   = dr[DIGIT_W];
                dcnt_next = last_dig ? '0 : dcnt_reg + 1'b1;
                if (last_dig)
                begin
                    if (close_blk)
                    begin
                        n_next    = held_inc;
                        held_next = '0;
                    end
                    else
                    begin
                        held_next = held_inc;
                    end
                end
            end

            // magnitudes: x ^ s + s
            ST_NEG_IN:
            begin
                lneg_next = lneg_cur;
                rneg_next = rneg_cur;
                dl        = digit_add(lsum_reg[DIGIT_W-1:0] ^ {DIGIT_W{lneg_cur}}, '0,
                                      first_dig ? lneg_cur : ca_reg);
                dr        = digit_add(rsum_reg[DIGIT_W-1:0] ^ {DIGIT_W{rneg_cur}}, '0,
                                      first_dig ? rneg_cur : cb_reg);
                lsum_next = {dl[DIGIT_W-1:0], lsum_reg[AW-1:DIGIT_W]};
                rsum_next = {dr[DIGIT_W-1:0], rsum_reg[AW-1:DIGIT_W]};
                ca_next   = dl[DIGIT_W];
                cb_next   = dr[DIGIT_W];
                dcnt_next = last_dig ? '0 : dcnt_reg + 1'b1;
                reml_next = '0;
                remr_next = '0;
                bcnt_next = '0;
            end

            // quotient bits shift in where the dividend bits leave
            ST_DIV:
            begin
                reml_next = qbl ? shl - {1'b0, n_reg} : shl;
                remr_next = qbr ? shr - {1'b0, n_reg} : shr;
                lsum_next = {lsum_reg[AW-2:0], qbl};
                rsum_next = {rsum_reg[AW-2:0], qbr};
                bcnt_next = last_bit ? '0 : bcnt_reg + 1'b1;
                dcnt_next = '0;
            end

            // put the signs back
            ST_NEG_OUT:
            begin
                dl        = digit_add(lsum_reg[DIGIT_W-1:0] ^ {DIGIT_W{lneg_reg}}, '0,
                                      first_dig ? lneg_reg : ca_reg);
                dr        = digit_add(rsum_reg[DIGIT_W-1:0] ^ {DIGIT_W{rneg_reg}}, '0,
                                      first_dig ? rneg_reg : cb_reg);
                lsum_next = {dl[DIGIT_W-1:0], lsum_reg[AW-1:DIGIT_W]};
                rsum_next = {dr[DIGIT_W-1:0], rsum_reg[AW-1:DIGIT_W]};
                ca_next   = dl[DIGIT_W];
                cb_next   = dr[DIGIT_W];
                dcnt_next = last_dig ? '0 : dcnt_reg + 1'b1;
                kcnt_next = CW'(1);
            end

            // hold the average; clear the sums after the last word
            ST_EMIT:
            begin
                if (result_acc)
                begin
                    if (result.run_last)
                    begin
                        lsum_next = '0;
                        rsum_next = '0;
                    end
                    else
                    begin
                        kcnt_next = kcnt_reg + 1'b1;
                    end
                end
            end

            default: ;
        endcase
    end

    // channel outputs
    always_comb
    begin
        frame.ready      = (state_reg == ST_IDLE);
        result.valid     = (state_reg == ST_EMIT);
        result.left_out  = FIELD_W'($signed(lsum_reg[SAMPLE_BITS-1:0]));
        result.right_out = mono_out ? '0
                           : FIELD_W'($signed(rsum_reg[SAMPLE_BITS-1:0]));
        result.run_last  = (kcnt_reg == n_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            loss_reg    <= LOSS_RESET;
            stereo_reg  <= 1'b1;
            downmix_reg <= 1'b0;
            held_reg    <= '0;
            n_reg       <= '0;
            kcnt_reg    <= '0;
            dcnt_reg    <= '0;
            bcnt_reg    <= '0;
            lsum_reg    <= '0;
            rsum_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            loss_reg    <= loss_next;
            stereo_reg  <= stereo_next;
            downmix_reg <= downmix_next;
            held_reg    <= held_next;
            n_reg       <= n_next;
            kcnt_reg    <= kcnt_next;
            dcnt_reg    <= dcnt_next;
            bcnt_reg    <= bcnt_next;
            lsum_reg    <= lsum_next;
            rsum_reg    <= rsum_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        lneg_reg <= lneg_next;
        rneg_reg <= rneg_next;
        eos_reg  <= eos_next;
        reml_reg <= reml_next;
        remr_reg <= remr_next;
    end

    // checks
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(held_reg) < MAX_LOSS)
        else $error("open block holds MAX_LOSS frames or more");

    a_kcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (kcnt_reg != '0) && (kcnt_reg <= n_reg))
        else $error("repeat count outside the block");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_acc && result.run_last) |=> !result.valid && frame.ready)
        else $error("words continue after the last of the block");

    a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (result_acc && result.run_last) |=> (lsum_reg == '0) && (rsum_reg == '0))
        else $error("sums not cleared after a block");

endmodule
